@@ design/cle_pkg.sv @@
// Shared types, character codes and helpers for the console line editor.
`default_nettype none

package cle_pkg;

    localparam int KIND_W  = 3;
    localparam int ERASE_W = 6;
    localparam int LEN_W   = 7;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LINE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EOF    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TAB    = 3'd4;

    // Received character codes
    localparam logic [7:0] CHAR_CTRL_C  = 8'd3;
    localparam logic [7:0] CHAR_CTRL_D  = 8'd4;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NL      = 8'd10;
    localparam logic [7:0] CHAR_CTRL_U  = 8'd21;
    localparam logic [7:0] CHAR_CTRL_W  = 8'd23;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_PRINT_HI = 8'd126;
    localparam logic [7:0] CHAR_DEL     = 8'd127;
    localparam logic [7:0] CHAR_UNDER   = 8'd95;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_EOT     = 3'd2,
        OP_DEL     = 3'd3,
        OP_WORD    = 3'd4,
        OP_KILL    = 3'd5,
        OP_CANCEL  = 3'd6,
        OP_TAB     = 3'd7
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               echo_valid;
        logic [7:0]         echo_char;
        logic [ERASE_W-1:0] erase_count;
        logic [7:0]         line_char;
        logic               last;
        logic [LEN_W-1:0]   line_length;
        logic               overflow;
    } res_t;

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122) || (c == CHAR_UNDER);
    endfunction

endpackage

`default_nettype wire

@@ design/console_line_editor_core.sv @@
// Console line editor top level: front end, command queue and back end.
//
// Takes one received console byte per transfer and edits a line of up to
// LINE_DEPTH-1 characters. Printable bytes are appended and echoed (dropped
// with the overflow flag when full); Delete, Ctrl-W and Ctrl-U erase one
// character, a word or the whole line; Ctrl-C cancels; newline, or Ctrl-D on
// a non-empty line, sends the stored line plus a newline as a run of line
// characters, the newline marked last. Ctrl-D on an empty line reports end of
// file and Tab raises a request. Unlisted control codes and bytes above 127
// are taken and give no result. The front end classifies a byte in the
// cycle it is taken and parks it in a two-entry queue, so input keeps
// flowing while the back end is busy until the queue is full. In the back
// end, Ctrl-W fetches the last character and scans down the line until a
// kept character stops it or the line is empty. A line readout is paced
// by the single read port of the line store, which needs a fetch first and
// then delivers one character per cycle while the output is free. Results
// leave through an output register, which holds them while m_ready is low.
`default_nettype none

module console_line_editor_core
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [KIND_W-1:0]       m_kind,
    output logic                    m_echo_valid,
    output logic [7:0]              m_echo_char,
    output logic [ERASE_W-1:0]      m_erase_count,
    output logic [7:0]              m_line_char,
    output logic                    m_last,
    output logic [LEN_W-1:0]        m_line_length,
    output logic                    m_overflow
);

    // front end to queue
    logic front_valid, front_ready;
    cmd_t front_cmd;

    // queue to back end
    logic q_valid, q_ready;
    cmd_t q_cmd;

    res_t res;

    // Classify each byte; unknown codes are dropped at the door.
    cle_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // Hold commands while the back end walks the line store.
    cle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // Carry out edits and readouts against the line store.
    cle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (res)
    );

    assign m_kind        = res.kind;
    assign m_echo_valid  = res.echo_valid;
    assign m_echo_char   = res.echo_char;
    assign m_erase_count = res.erase_count;
    assign m_line_char   = res.line_char;
    assign m_last        = res.last;
    assign m_line_length = res.line_length;
    assign m_overflow    = res.overflow;

`ifndef SYNTH
    // The newline closing a line run is always echoed and tagged as a line character.
    a_last_is_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> (m_kind == KIND_LINE) && m_echo_valid &&
                              (m_line_char == CHAR_NL))
        else $error("last flag outside a line run");

    // A dropped byte is never echoed and is reported as edit status.
    a_overflow_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> !m_echo_valid && (m_kind == KIND_STATUS))
        else $error("overflow result echoes or has wrong kind");

    // Inside a line run, nothing else may slip in before the closing newline.
    a_line_run_intact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_kind == KIND_LINE) && !m_last
        |=> !m_valid || (m_kind == KIND_LINE))
        else $error("line run interrupted");
`endif

endmodule

`default_nettype wire

@@ design/cle_front.sv @@
// Front end: takes received bytes and turns them into editor commands.
`default_nettype none

module cle_front
    import cle_pkg::*;
(
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            cmd_valid,
    input  wire logic       cmd_ready,
    output cmd_t            cmd
);

    logic known;

    always_comb begin
        known  = 1'b1;
        cmd.ch = s_rx_byte;
        cmd.op = OP_APPEND;
        priority if (s_rx_byte >= CHAR_SPACE && s_rx_byte <= CHAR_PRINT_HI) begin
            cmd.op = OP_APPEND;
        end else if (s_rx_byte == CHAR_NL) begin
            cmd.op = OP_NEWLINE;
        end else if (s_rx_byte == CHAR_CTRL_D) begin
            cmd.op = OP_EOT;
        end else if (s_rx_byte == CHAR_DEL) begin
            cmd.op = OP_DEL;
        end else if (s_rx_byte == CHAR_CTRL_W) begin
            cmd.op = OP_WORD;
        end else if (s_rx_byte == CHAR_CTRL_U) begin
            cmd.op = OP_KILL;
        end else if (s_rx_byte == CHAR_CTRL_C) begin
            cmd.op = OP_CANCEL;
        end else if (s_rx_byte == CHAR_TAB) begin
            cmd.op = OP_TAB;
        end else begin
            known = 1'b0;
        end
    end

    // Unknown bytes are taken and dropped here.
    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid && known;

endmodule

`default_nettype wire

@@ design/cle_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module cle_queue
    import cle_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PW:0]   fill_reg, fill_next;
    logic                push, pop;

    assign in_ready  = (fill_reg != (QUEUE_PW+1)'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QUEUE_PW+1)'(push) - (QUEUE_PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/cle_back.sv @@
// Back end: line store, edit commands, line readout and the result register.
`default_nettype none

module cle_back
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_res
);

    localparam int CW = $clog2(LINE_DEPTH);
    localparam logic [CW-1:0] MAX_COUNT = CW'(LINE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WFETCH = 5'b00010,
        S_WSCAN  = 5'b00100,
        S_WDONE  = 5'b01000,
        S_LINE   = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        MODE_SPACE = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_PUNCT = 2'd2
    } wmode_t;

    state_t        state_reg, state_next;
    wmode_t        mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          have_reg, have_next;
    logic          m_valid_reg, m_valid_next;
    res_t          m_res_reg, m_res_next;

    logic [7:0]    line_mem [LINE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          rd_en, wr_en;
    logic [CW-1:0] rd_addr;

    logic          out_free, emit, erase_it, c_word;
    res_t          res;
    logic [CW-1:0] n_minus1, n_minus2, idx_plus1;
    logic [CW:0]   len_plus1;

    function automatic logic [LEN_W-1:0] fit_len(input logic [CW:0] v);
        logic [CW+LEN_W:0] w;
        w = {{LEN_W{1'b0}}, v};
        return w[LEN_W-1:0];
    endfunction

    function automatic logic [ERASE_W-1:0] fit_erase(input logic [CW-1:0] v);
        logic [CW+ERASE_W-1:0] w;
        w = {{ERASE_W{1'b0}}, v};
        return w[ERASE_W-1:0];
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign n_minus1  = n_reg - 1'b1;
    assign n_minus2  = n_minus1 - 1'b1;
    assign idx_plus1 = idx_reg + 1'b1;
    assign len_plus1 = {1'b0, count_reg} + 1'b1;
    assign c_word    = is_name_char(rd_data_reg);

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        have_next  = have_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        cmd_ready  = 1'b0;
        emit       = 1'b0;
        erase_it   = 1'b0;
        res        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    unique case (cmd.op)
                        OP_APPEND: begin
                            emit = 1'b1;
                            if (count_reg < MAX_COUNT) begin
                                wr_en           = 1'b1;
                                count_next      = count_reg + 1'b1;
                                res.echo_valid  = 1'b1;
                                res.echo_char   = cmd.ch;
                                res.line_length = fit_len(len_plus1);
                            end else begin
                                res.overflow    = 1'b1;
                                res.line_length = fit_len({1'b0, count_reg});
                            end
                        end
                        OP_NEWLINE: begin
                            state_next = S_LINE;
                            idx_next   = '0;
                            have_next  = 1'b0;
                        end
                        OP_EOT: begin
                            if (count_reg != '0) begin
                                state_next = S_LINE;
                                idx_next   = '0;
                                have_next  = 1'b0;
                            end else begin
                                emit     = 1'b1;
                                res.kind = KIND_EOF;
                            end
                        end
                        OP_DEL: begin
                            emit = 1'b1;
                            if (count_reg != '0) begin
                                count_next      = count_reg - 1'b1;
                                res.erase_count = fit_erase(CW'(1));
                                res.line_length = fit_len({1'b0, count_reg - 1'b1});
                            end
                        end
                        OP_WORD: begin
                            if (count_reg != '0) begin
                                state_next = S_WFETCH;
                                mode_next  = MODE_SPACE;
                                n_next     = count_reg;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        OP_KILL: begin
                            emit            = 1'b1;
                            res.erase_count = fit_erase(count_reg);
                            count_next      = '0;
                        end
                        OP_CANCEL: begin
                            emit           = 1'b1;
                            res.kind       = KIND_CANCEL;
                            res.echo_valid = 1'b1;
                            res.echo_char  = CHAR_NL;
                            count_next     = '0;
                        end
                        OP_TAB: begin
                            emit            = 1'b1;
                            res.kind        = KIND_TAB;
                            res.line_length = fit_len({1'b0, count_reg});
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_WFETCH: begin
                rd_en      = 1'b1;
                rd_addr    = n_minus1;
                state_next = S_WSCAN;
            end
            S_WSCAN: begin
                unique case (mode_reg)
                    MODE_WORD:  erase_it = c_word;
                    MODE_PUNCT: erase_it = !c_word && (rd_data_reg != CHAR_SPACE);
                    default: begin
                        erase_it = 1'b1;
                        if (c_word) begin
                            mode_next = MODE_WORD;
                        end else if (rd_data_reg != CHAR_SPACE) begin
                            mode_next = MODE_PUNCT;
                        end
                    end
                endcase
                if (erase_it) begin
                    n_next = n_minus1;
                    if (n_minus1 == '0) begin
                        state_next = S_WDONE;
                    end else begin
                        // fetch the next character down while this one retires
                        rd_en   = 1'b1;
                        rd_addr = n_minus2;
                    end
                end else begin
                    state_next = S_WDONE;
                end
            end
            S_WDONE: begin
                if (out_free) begin
                    emit            = 1'b1;
                    res.erase_count = fit_erase(count_reg - n_reg);
                    res.line_length = fit_len({1'b0, n_reg});
                    count_next      = n_reg;
                    state_next      = S_IDLE;
                end
            end
            S_LINE: begin
                if (idx_reg == count_reg) begin
                    if (out_free) begin
                        emit            = 1'b1;
                        res.kind        = KIND_LINE;
                        res.echo_valid  = 1'b1;
                        res.echo_char   = CHAR_NL;
                        res.line_char   = CHAR_NL;
                        res.last        = 1'b1;
                        res.line_length = fit_len(len_plus1);
                        count_next      = '0;
                        state_next      = S_IDLE;
                    end
                end else if (!have_reg) begin
                    rd_en     = 1'b1;
                    rd_addr   = idx_reg;
                    have_next = 1'b1;
                end else if (out_free) begin
                    emit            = 1'b1;
                    res.kind        = KIND_LINE;
                    res.line_char   = rd_data_reg;
                    res.line_length = fit_len(len_plus1);
                    idx_next        = idx_plus1;
                    if (idx_plus1 != count_reg) begin
                        rd_en   = 1'b1;
                        rd_addr = idx_plus1;
                    end else begin
                        have_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_res_next   = emit ? res : m_res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        m_res_reg <= m_res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[count_reg] <= cmd.ch;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

`default_nettype wire
